FILE: hw/rtl/hvt_pkg.sv
// Shared types and constants for the homogeneous vector transform unit.
`timescale 1ns / 1ps
package hvt_pkg;

   localparam int LANES      = 4;
   localparam int COEF_W     = 16;
   localparam int VEC_W      = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Register map, eight bytes apart.
   typedef enum logic [1:0] {
      REG_COEF_X = 2'd0,
      REG_COEF_Y = 2'd1,
      REG_COEF_Z = 2'd2,
      REG_COEF_W = 2'd3
   } reg_index_type;

   // Reset values form the identity matrix in Q4.12.
   localparam logic [CSR_DATA_W-1:0] RESET_COEF_X = 64'h0000_0000_0000_1000;
   localparam logic [CSR_DATA_W-1:0] RESET_COEF_Y = 64'h0000_0000_1000_0000;
   localparam logic [CSR_DATA_W-1:0] RESET_COEF_Z = 64'h0000_1000_0000_0000;
   localparam logic [CSR_DATA_W-1:0] RESET_COEF_W = 64'h1000_0000_0000_0000;

   localparam logic [VEC_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [VEC_W-1:0] S32_MIN = 32'h8000_0000;

   // Side data that travels alongside the divider pipeline.
   typedef struct packed {
      logic [LANES-1:0][VEC_W-1:0] r;
      logic [VEC_W-1:0]            den;
      logic [2:0]                  neg;
      logic                        div;
      logic                        sat;
   } side_type;

endpackage

FILE: hw/rtl/hvt_req_if.sv
// Request channel carrying one input vector.
`timescale 1ns / 1ps
interface hvt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;
   logic signed [31:0] in_w;

   modport source (output valid, in_x, in_y, in_z, in_w, input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

FILE: hw/rtl/hvt_rsp_if.sv
// Response channel carrying one transformed vector and its flags.
`timescale 1ns / 1ps
interface hvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [31:0] out_w;
   logic               divided;
   logic               saturated;

   modport source (output valid, out_x, out_y, out_z, out_w, divided, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, divided, saturated,
                   output ready);
endinterface

FILE: hw/rtl/homogeneous_vector_transform_unit.sv
// Top level of the homogeneous vector transform unit.
// Multiplies each request (x, y, z, w in signed Q16.16) by a 4x4 matrix of signed
// Q4.12 coefficients held in four 64-bit registers at byte addresses 0, 8, 16 and 24,
// floors and saturates each dot product to 32 bits, and when w is neither 1.0 nor 0
// divides x, y and z by w (truncating toward zero, saturating) and sets w to 1.0.
// One request is accepted every clock cycle unless a response is held back; the divider
// resolves one quotient bit per pipeline stage. The whole pipeline holds while a
// response waits to be taken.
// Coefficients must only be written while no request is in flight.
`timescale 1ns / 1ps
module homogeneous_vector_transform_unit #(
   parameter int COEF_FRAC_BITS = 12,
   parameter int VEC_FRAC_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   hvt_req_if.sink                         req,
   hvt_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hvt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hvt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hvt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import hvt_pkg::*;

   localparam int PROD_W = COEF_W + VEC_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int NUM_W  = VEC_W + VEC_FRAC_BITS;
   localparam logic [VEC_W-1:0] ONE = VEC_W'(1) << VEC_FRAC_BITS;
   localparam logic [NUM_W-1:0] Q_MAX_POS = NUM_W'(S32_MAX);
   localparam logic [NUM_W-1:0] Q_MAX_NEG = NUM_W'(S32_MIN);

   // Pipeline advances unless a response is held back.
   logic adv;

   // Coefficient registers
   logic [CSR_DATA_W-1:0] coef_ff [LANES];
   logic [1:0]            csr_index;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign csr_prdata = coef_ff[csr_index];

   // A write lands in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_COEF_X] <= RESET_COEF_X;
         coef_ff[REG_COEF_Y] <= RESET_COEF_Y;
         coef_ff[REG_COEF_Z] <= RESET_COEF_Z;
         coef_ff[REG_COEF_W] <= RESET_COEF_W;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         coef_ff[csr_index] <= csr_pwdata;
      end
   end

   // Stage 1: sixteen products.
   logic [VEC_W-1:0]         vec [LANES];
   logic signed [PROD_W-1:0] prod_in [LANES][LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES][LANES];
   logic                     s1_valid_ff;

   assign vec[0] = req.in_x;
   assign vec[1] = req.in_y;
   assign vec[2] = req.in_z;
   assign vec[3] = req.in_w;

   always_comb begin
      logic signed [PROD_W-1:0] c_ext;
      logic signed [PROD_W-1:0] v_ext;
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            c_ext = {{VEC_W{coef_ff[i][COEF_W*j+COEF_W-1]}},
                     coef_ff[i][COEF_W*j +: COEF_W]};
            v_ext = {{COEF_W{vec[i][VEC_W-1]}}, vec[i]};
            prod_in[i][j] = c_ext * v_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   // Stage 2: pairwise sums.
   logic signed [PAIR_W-1:0] pair_ff [LANES][2];
   logic                     s2_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < LANES; j++) begin
            pair_ff[j][0] <= PAIR_W'(prod_ff[0][j]) + PAIR_W'(prod_ff[1][j]);
            pair_ff[j][1] <= PAIR_W'(prod_ff[2][j]) + PAIR_W'(prod_ff[3][j]);
         end
      end
   end

   // Stage 3: full dot products.
   logic signed [SUM_W-1:0] sum_ff [LANES];
   logic                    s3_valid_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < LANES; j++) begin
            sum_ff[j] <= SUM_W'(pair_ff[j][0]) + SUM_W'(pair_ff[j][1]);
         end
      end
   end

   // Stage 4: floor the fraction away and saturate to 32 bits.
   logic [VEC_W-1:0] dot_in [LANES];
   logic [VEC_W-1:0] dot_ff [LANES];
   logic             dot_sat_in;
   logic             dot_sat_ff;
   logic             s4_valid_ff;

   always_comb begin
      logic signed [SUM_W-1:0] shifted;
      logic                    ovf;
      dot_sat_in = 1'b0;
      for (int j = 0; j < LANES; j++) begin
         shifted = sum_ff[j] >>> COEF_FRAC_BITS;
         ovf = !((&shifted[SUM_W-1:VEC_W-1]) || !(|shifted[SUM_W-1:VEC_W-1]));
         if (ovf) begin
            dot_in[j] = shifted[SUM_W-1] ? S32_MIN : S32_MAX;
         end else begin
            dot_in[j] = shifted[VEC_W-1:0];
         end
         dot_sat_in = dot_sat_in | ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dot_ff     <= dot_in;
         dot_sat_ff <= dot_sat_in;
      end
   end

   // Stage 5: set up magnitudes and signs for the divider.
   logic [NUM_W-1:0] dq_ff    [NUM_W+1][3];
   logic [VEC_W-1:0] rem_ff   [NUM_W+1][3];
   side_type         side_ff  [NUM_W+1];
   logic             dv_valid_ff [NUM_W+1];
   side_type         side_in;
   logic [NUM_W-1:0] num_in [3];

   always_comb begin
      logic [VEC_W-1:0] mag;
      side_in.r   = {dot_ff[3], dot_ff[2], dot_ff[1], dot_ff[0]};
      side_in.den = dot_ff[3][VEC_W-1] ? (~dot_ff[3] + VEC_W'(1)) : dot_ff[3];
      side_in.div = (dot_ff[3] != ONE) && (dot_ff[3] != '0);
      side_in.sat = dot_sat_ff;
      for (int j = 0; j < 3; j++) begin
         mag = dot_ff[j][VEC_W-1] ? (~dot_ff[j] + VEC_W'(1)) : dot_ff[j];
         num_in[j] = {mag, {VEC_FRAC_BITS{1'b0}}};
         side_in.neg[j] = dot_ff[j][VEC_W-1] ^ dot_ff[3][VEC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int j = 0; j < 3; j++) begin
            dq_ff[0][j]  <= num_in[j];
            rem_ff[0][j] <= '0;
         end
      end
   end

   // Divider: one restoring step per stage, quotient bits shift in at the bottom.
   for (genvar k = 1; k <= NUM_W; k++) begin : g_div
      logic [VEC_W:0]   trial [3];
      logic             ge    [3];

      always_comb begin
         for (int j = 0; j < 3; j++) begin
            trial[j] = {rem_ff[k-1][j], dq_ff[k-1][j][NUM_W-1]};
            ge[j]    = trial[j] >= {1'b0, side_ff[k-1].den};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_ff[k-1];
            for (int j = 0; j < 3; j++) begin
               if (ge[j]) begin
                  rem_ff[k][j] <= VEC_W'(trial[j] - {1'b0, side_ff[k-1].den});
               end else begin
                  rem_ff[k][j] <= trial[j][VEC_W-1:0];
               end
               dq_ff[k][j] <= {dq_ff[k-1][j][NUM_W-2:0], ge[j]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end
   end

   // Output stage: restore signs, saturate quotients, pick the result.
   logic [VEC_W-1:0] res_in [LANES];
   logic [VEC_W-1:0] res_ff [LANES];
   logic             sat_in;
   logic             sat_ff;
   logic             div_ff;
   logic             rsp_valid_ff;

   always_comb begin
      logic [NUM_W-1:0] q;
      side_type         sd;
      sd     = side_ff[NUM_W];
      sat_in = sd.sat;
      for (int j = 0; j < 3; j++) begin
         q = dq_ff[NUM_W][j];
         if (!sd.div) begin
            res_in[j] = sd.r[j];
         end else if (sd.neg[j]) begin
            if (q > Q_MAX_NEG) begin
               res_in[j] = S32_MIN;
               sat_in    = 1'b1;
            end else begin
               res_in[j] = ~q[VEC_W-1:0] + VEC_W'(1);
            end
         end else begin
            if (q > Q_MAX_POS) begin
               res_in[j] = S32_MAX;
               sat_in    = 1'b1;
            end else begin
               res_in[j] = q[VEC_W-1:0];
            end
         end
      end
      res_in[3] = sd.div ? ONE : sd.r[3];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         div_ff <= side_ff[NUM_W].div;
      end
   end

   // Valid bits for the arithmetic stages and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         dv_valid_ff[0] <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= req.valid;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         s4_valid_ff    <= s3_valid_ff;
         dv_valid_ff[0] <= s4_valid_ff;
         rsp_valid_ff   <= dv_valid_ff[NUM_W];
      end
   end

   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_x     = res_ff[0];
   assign rsp.out_y     = res_ff[1];
   assign rsp.out_z     = res_ff[2];
   assign rsp.out_w     = res_ff[3];
   assign rsp.divided   = div_ff;
   assign rsp.saturated = sat_ff;

endmodule

FILE: hw/rtl/hvt_checker.sv
// Port-level checks for the homogeneous vector transform unit, bound to the top level.
`timescale 1ns / 1ps
module hvt_checker #(
   parameter int VEC_FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] out_x,
   input logic [31:0] out_w,
   input logic        divided
);
   localparam logic [31:0] ONE = 32'(1) << VEC_FRAC_BITS;

   // A held response stays valid and keeps its x value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x))
      else $error("held response changed");

   // The pipeline takes no request while a response is held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted during stall");

   // A divided vector leaves with w at unity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divided |-> out_w == ONE)
      else $error("divided response without unit w");

   // Without a divide, w can only be zero or unity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !divided |-> (out_w == ONE || out_w == 32'd0))
      else $error("divide skipped for general w");

   // Nothing leaves straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind homogeneous_vector_transform_unit hvt_checker #(
   .VEC_FRAC_BITS(VEC_FRAC_BITS)
) u_hvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .out_x     (rsp.out_x),
   .out_w     (rsp.out_w),
   .divided   (rsp.divided)
);
